### rtl/core/bdcc_pkg.sv
// Shared types, constants and lookup tables for the button dimmer color controller.
// Used by bdcc_ctrl, bdcc_datapath and button_dimmer_color_controller.
`timescale 1ns / 1ps
`default_nettype none

package bdcc_pkg;

    // Default table sizes
    localparam int BRIGHT_STEPS_DEF = 7;
    localparam int COLOUR_COUNT_DEF = 7;

    // Buttons, in the order their releases are applied
    localparam int NUM_BUTTONS = 4;
    localparam int BTN_UP      = 0;
    localparam int BTN_DOWN    = 1;
    localparam int BTN_LEFT    = 2;
    localparam int BTN_RIGHT   = 3;

    // Configuration register indexes
    localparam logic CFG_LONG_PRESS = 1'b0;
    localparam logic CFG_WAKE_STEP  = 1'b1;

    // Configuration reset values
    localparam logic [7:0] LONG_PRESS_RST = 8'd10;
    localparam logic [2:0] WAKE_STEP_RST  = 3'd3;

    // Fill colors, 0xRRGGBB
    localparam logic [23:0] COL_RED     = 24'hFF0000;
    localparam logic [23:0] COL_YELLOW  = 24'hFFFF00;
    localparam logic [23:0] COL_GREEN   = 24'h00FF00;
    localparam logic [23:0] COL_CYAN    = 24'h00FFFF;
    localparam logic [23:0] COL_BLUE    = 24'h0000FF;
    localparam logic [23:0] COL_MAGENTA = 24'hFF00FF;
    localparam logic [23:0] COL_WHITE   = 24'hFFFFFF;

    // Reciprocals for divide by 31 and by 63, exact over the expand range
    localparam logic [15:0] RECIP31     = 16'd33826;
    localparam logic [15:0] RECIP63     = 16'd16645;
    localparam int          RECIP_SHIFT = 20;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_QUANT,
        ST_EXPAND
    } bdcc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // apply button events of the incoming beat
        logic scale;    // capture channel * brightness
        logic quant;    // capture RGB565 quantized channels
        logic load;     // load the output register
    } bdcc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // output register empty or draining this cycle
    } bdcc_status_t;

    // Brightness level per step
    function automatic logic [7:0] level_of(input logic [3:0] step);
        logic [7:0] lvl;
        unique case (step) inside
            4'd0:    lvl = 8'd0;
            4'd1:    lvl = 8'd7;
            4'd2:    lvl = 8'd15;
            4'd3:    lvl = 8'd31;
            4'd4:    lvl = 8'd63;
            4'd5:    lvl = 8'd127;
            default: lvl = 8'd255;
        endcase
        return lvl;
    endfunction

    // Base color per index, repeating every seven entries
    function automatic logic [23:0] colour_of(input logic [3:0] idx);
        logic [23:0] col;
        unique case (idx) inside
            4'd0, 4'd7, 4'd14:  col = COL_RED;
            4'd1, 4'd8, 4'd15:  col = COL_YELLOW;
            4'd2, 4'd9:         col = COL_GREEN;
            4'd3, 4'd10:        col = COL_CYAN;
            4'd4, 4'd11:        col = COL_BLUE;
            4'd5, 4'd12:        col = COL_MAGENTA;
            default:            col = COL_WHITE;
        endcase
        return col;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bdcc_ctrl.sv
// Sequencer for the button dimmer color controller: steps one beat through
// event, scale, quantize and expand phases. Depends on bdcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdcc_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire bdcc_pkg::bdcc_status_t  status,
    output bdcc_pkg::bdcc_cmd_t          cmd
);

    bdcc_pkg::bdcc_state_t state_reg;
    bdcc_pkg::bdcc_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdcc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            bdcc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = bdcc_pkg::ST_SCALE;
                end
            end
            bdcc_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = bdcc_pkg::ST_QUANT;
            end
            bdcc_pkg::ST_QUANT:
            begin
                cmd.quant  = 1'b1;
                state_next = bdcc_pkg::ST_EXPAND;
            end
            bdcc_pkg::ST_EXPAND:
            begin
                // wait here while the previous result is still unclaimed
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = bdcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdcc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/bdcc_datapath.sv
// Datapath of the button dimmer color controller: hold counters, step and
// color state, scaling, RGB565 round trip and output register. Uses bdcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdcc_datapath #(
    parameter int BRIGHT_STEPS = bdcc_pkg::BRIGHT_STEPS_DEF,
    parameter int COLOUR_COUNT = bdcc_pkg::COLOUR_COUNT_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire bdcc_pkg::bdcc_cmd_t     cmd,
    output bdcc_pkg::bdcc_status_t       status,
    input  wire logic [3:0]              buttons,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_addr,
    input  wire logic [7:0]              cfg_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [39:0]                  out_data
);

    localparam int SW = $clog2(BRIGHT_STEPS);
    localparam int CW = $clog2(COLOUR_COUNT);
    localparam logic [SW-1:0] STEP_MAX = SW'(BRIGHT_STEPS - 1);
    localparam logic [CW-1:0] COL_MAX  = CW'(COLOUR_COUNT - 1);

    // floor(x / 255) for x below 65535
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = 17'(x) + 17'd1 + 17'(x >> 8);
        return 8'(sum >> 8);
    endfunction

    // Configuration
    logic [7:0]    long_press_reg;
    logic [2:0]    wake_step_reg;

    // Control state
    logic [7:0]    hold_reg [bdcc_pkg::NUM_BUTTONS];
    logic [7:0]    hold_next [bdcc_pkg::NUM_BUTTONS];
    logic [SW-1:0] bright_step_reg;
    logic [SW-1:0] bright_step_next;
    logic [CW-1:0] colour_step_reg;
    logic [CW-1:0] colour_step_next;
    logic [7:0]    level_reg;
    logic [7:0]    level_next;
    logic [23:0]   base_reg;
    logic [23:0]   base_next;
    logic          pairing_reg;
    logic          pairing_next;
    logic          out_valid_reg;

    // Release events per button
    logic [bdcc_pkg::NUM_BUTTONS-1:0] ev_short;
    logic [bdcc_pkg::NUM_BUTTONS-1:0] ev_long;
    logic [4:0]    wake_ext;
    logic [SW-1:0] wake_clamped;

    // Pipeline payload
    logic [15:0]   red_prod;
    logic [15:0]   green_prod;
    logic [15:0]   blue_prod;
    logic [7:0]    red_scl_reg;
    logic [7:0]    green_scl_reg;
    logic [7:0]    blue_scl_reg;
    logic [13:0]   red_num;
    logic [13:0]   green_num;
    logic [12:0]   blue_num;
    logic [4:0]    red_q_reg;
    logic [5:0]    green_q_reg;
    logic [4:0]    blue_q_reg;
    logic [13:0]   red_x;
    logic [13:0]   green_x;
    logic [13:0]   blue_x;
    logic [27:0]   red_y;
    logic [27:0]   green_y;
    logic [27:0]   blue_y;
    logic [7:0]    out_red_reg;
    logic [7:0]    out_green_reg;
    logic [7:0]    out_blue_reg;
    logic [7:0]    out_bright_reg;
    logic [2:0]    out_colour_reg;
    logic          out_pairing_reg;
    logic [7:0]    colour_wide;

    // Hold counters and release classification
    always_comb
    begin
        for (int i = 0; i < bdcc_pkg::NUM_BUTTONS; i++)
        begin
            ev_short[i]  = 1'b0;
            ev_long[i]   = 1'b0;
            hold_next[i] = hold_reg[i];
            if (buttons[i])
            begin
                if (hold_reg[i] != 8'hFF)
                begin
                    hold_next[i] = hold_reg[i] + 8'd1;
                end
            end
            else if (hold_reg[i] != 8'd0)
            begin
                hold_next[i] = 8'd0;
                if (hold_reg[i] >= long_press_reg)
                begin
                    ev_long[i] = 1'b1;
                end
                else
                begin
                    ev_short[i] = 1'b1;
                end
            end
        end
    end

    // Wake step clamped to the table
    assign wake_ext     = 5'(wake_step_reg);
    assign wake_clamped = (wake_ext > 5'(BRIGHT_STEPS - 1)) ? STEP_MAX : SW'(wake_ext);

    // Apply releases in order up, down, left, right
    always_comb
    begin
        bright_step_next = bright_step_reg;
        level_next       = level_reg;
        colour_step_next = colour_step_reg;
        base_next        = base_reg;
        pairing_next     = 1'b0;

        if (ev_long[bdcc_pkg::BTN_UP])
        begin
            pairing_next = 1'b1;
        end
        else if (ev_short[bdcc_pkg::BTN_UP])
        begin
            if (bright_step_next != STEP_MAX)
            begin
                bright_step_next = bright_step_next + SW'(1);
            end
            level_next = bdcc_pkg::level_of(4'(bright_step_next));
        end

        if (ev_short[bdcc_pkg::BTN_DOWN])
        begin
            if (bright_step_next != '0)
            begin
                bright_step_next = bright_step_next - SW'(1);
            end
            level_next = bdcc_pkg::level_of(4'(bright_step_next));
        end

        if (ev_short[bdcc_pkg::BTN_LEFT])
        begin
            colour_step_next = (colour_step_next == COL_MAX) ? '0
                                                             : colour_step_next + CW'(1);
            base_next = bdcc_pkg::colour_of(4'(colour_step_next));
            if (level_next == 8'd0)
            begin
                bright_step_next = wake_clamped;
                level_next       = bdcc_pkg::level_of(4'(wake_clamped));
            end
        end

        if (ev_short[bdcc_pkg::BTN_RIGHT])
        begin
            colour_step_next = (colour_step_next == '0) ? COL_MAX
                                                        : colour_step_next - CW'(1);
            base_next = bdcc_pkg::colour_of(4'(colour_step_next));
            if (level_next == 8'd0)
            begin
                bright_step_next = wake_clamped;
                level_next       = bdcc_pkg::level_of(4'(wake_clamped));
            end
        end
    end

    // Configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg  <= bdcc_pkg::LONG_PRESS_RST;
            wake_step_reg   <= bdcc_pkg::WAKE_STEP_RST;
            for (int i = 0; i < bdcc_pkg::NUM_BUTTONS; i++)
            begin
                hold_reg[i] <= 8'd0;
            end
            bright_step_reg <= '0;
            colour_step_reg <= '0;
            level_reg       <= 8'd0;
            base_reg        <= bdcc_pkg::COL_WHITE;
            pairing_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    bdcc_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_data;
                    bdcc_pkg::CFG_WAKE_STEP:  wake_step_reg  <= cfg_data[2:0];
                endcase
            end
            if (cmd.accept)
            begin
                for (int i = 0; i < bdcc_pkg::NUM_BUTTONS; i++)
                begin
                    hold_reg[i] <= hold_next[i];
                end
                bright_step_reg <= bright_step_next;
                colour_step_reg <= colour_step_next;
                level_reg       <= level_next;
                base_reg        <= base_next;
                pairing_reg     <= pairing_next;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scale: channel * brightness >> 8
    assign red_prod   = 16'(base_reg[23:16]) * 16'(level_reg);
    assign green_prod = 16'(base_reg[15:8])  * 16'(level_reg);
    assign blue_prod  = 16'(base_reg[7:0])   * 16'(level_reg);

    // Quantize to 5/6/5 bits with rounding
    assign red_num   = 14'(red_scl_reg) * 14'd62 + 14'd255;
    assign green_num = 14'(green_scl_reg) * 14'd63 + 14'd127;
    assign blue_num  = 13'(blue_scl_reg) * 13'd31 + 13'd127;

    // Expand back to 8 bits with rounding
    assign red_x   = 14'(red_q_reg) * 14'd255 + 14'd15;
    assign green_x = 14'(green_q_reg) * 14'd255 + 14'd31;
    assign blue_x  = 14'(blue_q_reg) * 14'd255 + 14'd15;
    assign red_y   = 28'(red_x) * 28'(bdcc_pkg::RECIP31);
    assign green_y = 28'(green_x) * 28'(bdcc_pkg::RECIP63);
    assign blue_y  = 28'(blue_x) * 28'(bdcc_pkg::RECIP31);

    assign colour_wide = 8'(colour_step_reg);

    // Payload pipeline and output register
    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            red_scl_reg   <= red_prod[15:8];
            green_scl_reg <= green_prod[15:8];
            blue_scl_reg  <= blue_prod[15:8];
        end
        if (cmd.quant)
        begin
            red_q_reg   <= 5'(div255(16'(red_num[13:1])));
            green_q_reg <= 6'(div255(16'(green_num)));
            blue_q_reg  <= 5'(div255(16'(blue_num)));
        end
        if (cmd.load)
        begin
            out_red_reg     <= 8'(red_y >> bdcc_pkg::RECIP_SHIFT);
            out_green_reg   <= 8'(green_y >> bdcc_pkg::RECIP_SHIFT);
            out_blue_reg    <= 8'(blue_y >> bdcc_pkg::RECIP_SHIFT);
            out_bright_reg  <= level_reg;
            out_colour_reg  <= colour_wide[2:0];
            out_pairing_reg <= pairing_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = {4'b0000, out_pairing_reg, out_colour_reg, out_bright_reg,
                              out_blue_reg, out_green_reg, out_red_reg};

endmodule

`default_nettype wire

### rtl/core/button_dimmer_color_controller.sv
// Top level of the button dimmer color controller: sequencer plus datapath.
// Depends on bdcc_pkg, bdcc_ctrl and bdcc_datapath.
//
//   Port group   Dir  Width  Contents
//   s_*          in   8      one button sample per beat
//   m_*          out  40     fill color, brightness, color index, pairing flag
//   cfg_*        in   1 / 8  register writes, no read-back
//
// An accepted beat runs in order: events are applied at acceptance, then the
// scale multiply, RGB565 quantize and expand phases follow in turn.
// The next beat is accepted once the result sits in the output register.
// If that register still holds an unclaimed beat, expand waits for m_tready.
// Reset: all hold counters zero, lamp dark, color white, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none

module button_dimmer_color_controller #(
    parameter int BRIGHT_STEPS = bdcc_pkg::BRIGHT_STEPS_DEF,
    parameter int COLOUR_COUNT = bdcc_pkg::COLOUR_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] up_pressed, [1] down_pressed, [2] left_pressed, [3] right_pressed
    input  wire logic [7:0]  s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] led_red, [15:8] led_green, [23:16] led_blue,
    // [31:24] brightness_out, [34:32] colour_out, [35] pairing_request
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_data
);

    bdcc_pkg::bdcc_cmd_t    cmd;
    bdcc_pkg::bdcc_status_t status;

    bdcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bdcc_datapath #(
        .BRIGHT_STEPS (BRIGHT_STEPS),
        .COLOUR_COUNT (COLOUR_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .buttons   (s_tdata[3:0]),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // Output register is never overwritten while it holds an unclaimed beat
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // An accepted beat always moves on to the scale phase
    a_accept_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (cmd.scale && !s_tready))
        else $error("accepted beat did not advance");

    // A load presents a result on the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire
